// File: hdl/dda_pkg.sv
// Shared constants, payload structs and control/status types for the DDA line rasterizer.
`default_nettype none

package dda_pkg;

    localparam int FRAME_WIDTH     = 64;
    localparam int FRAME_HEIGHT    = 64;
    localparam int COORD_FRAC_BITS = 4;

    localparam int COORD_W = 16;
    localparam int COLOR_W = 32;
    localparam int ADDR_W  = 12;

    localparam int MAX_DIM = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
    localparam int IDX_W   = $clog2(MAX_DIM);

    // coordinate difference, Q16 slope, major offset, product, minor value
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SLOPE_FRAC = 16;
    localparam int QUO_W      = 17;
    localparam int SLOPE_W    = QUO_W + 1;
    localparam int OFF_W      = 18;
    localparam int PROD_W     = SLOPE_W + OFF_W;
    localparam int MINOR_W    = PROD_W - SLOPE_FRAC;

    localparam int DIV_STEPS = QUO_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic signed [OFF_W-1:0]   OFF_STEP   = OFF_W'(1 << COORD_FRAC_BITS);
    localparam logic signed [PROD_W-1:0]  Q_ROUND    = PROD_W'((1 << SLOPE_FRAC) - 1);
    localparam logic signed [MINOR_W-1:0] PIX_ROUND  = MINOR_W'((1 << COORD_FRAC_BITS) - 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [COLOR_W-1:0]        line_color;
    } line_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  pixel_address;
        logic [COLOR_W-1:0] pixel_color;
        logic               write_enable;
        logic               last_pixel;
    } pixel_out_t;

    typedef struct packed {
        logic capture;
        logic order;
        logic prep;
        logic div_start;
        logic div_step;
        logic slope_load;
        logic step_en;
    } cmd_t;

    typedef struct packed {
        logic empty_line;
        logic issue_last;
        logic advance;
        logic pipe_idle;
    } stat_t;

endpackage

`default_nettype wire

// File: hdl/dda_div.sv
// Restoring divider, one quotient bit per cycle, for the Q16 slope magnitude.
`default_nettype none

module dda_div (
    input  wire logic                         clk,
    input  wire logic                         start,
    input  wire logic                         step,
    input  wire logic [dda_pkg::COORD_W-1:0]  dividend_abs,
    input  wire logic [dda_pkg::COORD_W-1:0]  divisor,
    output logic      [dda_pkg::QUO_W-1:0]    quotient
);

    logic [dda_pkg::COORD_W-1:0] rem_reg;
    logic                        feed_reg;
    logic [dda_pkg::QUO_W-1:0]   quo_reg;
    logic [dda_pkg::DIFF_W-1:0]  trial;
    logic [dda_pkg::DIFF_W-1:0]  diff;
    logic                        fits;

    // dividend is |dmin| << 16 and |dmin| <= divisor, so the quotient has 17 bits
    // and the top 15 dividend bits seed the remainder
    assign trial = {rem_reg, feed_reg};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, dividend_abs[dda_pkg::COORD_W-1:1]};
            feed_reg <= dividend_abs[0];
            quo_reg  <= '0;
        end
        else if (step)
        begin
            rem_reg  <= fits ? diff[dda_pkg::COORD_W-1:0] : trial[dda_pkg::COORD_W-1:0];
            feed_reg <= 1'b0;
            quo_reg  <= {quo_reg[dda_pkg::QUO_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: hdl/dda_dp.sv
// Datapath: endpoint ordering, slope division, stepping counter and the pixel pipeline.
`default_nettype none

module dda_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dda_pkg::line_in_t   line_data,
    input  wire dda_pkg::cmd_t       cmd,
    output dda_pkg::stat_t           stat,
    input  wire logic                pixel_ready,
    output logic                     pixel_valid,
    output dda_pkg::pixel_out_t      pixel_data
);

    dda_pkg::line_in_t in_reg;

    // ordering
    logic signed [dda_pkg::DIFF_W-1:0]  dx, dy;
    logic        [dda_pkg::DIFF_W-1:0]  adx, ady;
    logic                               xmaj;
    logic signed [dda_pkg::COORD_W-1:0] amaj, amin, bmaj, bmin;
    logic                               a_far;

    logic                               xmaj_reg;
    logic signed [dda_pkg::COORD_W-1:0] far_maj_reg, far_min_reg, near_maj_reg, near_min_reg;

    // line setup
    logic signed [dda_pkg::DIFF_W-1:0]  dmaj_full, dmin_full;
    logic signed [dda_pkg::COORD_W-1:0] near_px, far_px;
    logic        [dda_pkg::COORD_W-1:0] start_full, far_full, maj_lim, last_full;
    logic                               empty;
    logic        [dda_pkg::OFF_W+1:0]   start_scaled;
    logic signed [dda_pkg::OFF_W+1:0]   off_calc;

    logic [dda_pkg::COORD_W-1:0] dmaj_reg, dmin_abs_reg;
    logic                        dmin_neg_reg;
    logic                        empty_reg;

    logic [dda_pkg::QUO_W-1:0]          quotient;
    logic signed [dda_pkg::SLOPE_W-1:0] slope_reg;

    // stepping
    logic [dda_pkg::IDX_W-1:0]        m_reg, last_reg;
    logic signed [dda_pkg::OFF_W-1:0] off_reg;
    logic                             advance, issue;

    // pipeline
    logic                               v1_reg, v2_reg, out_valid_reg;
    logic signed [dda_pkg::PROD_W-1:0]  prod_s1_reg;
    logic [dda_pkg::IDX_W-1:0]          m_s1_reg, m_s2_reg;
    logic                               last_s1_reg, last_s2_reg;
    logic signed [dda_pkg::MINOR_W-1:0] minor_s2_reg;
    dda_pkg::pixel_out_t                out_reg;

    logic signed [dda_pkg::PROD_W-1:0]  prod_calc, prod_adj;
    logic signed [dda_pkg::MINOR_W-1:0] q_val, minor_calc, minor_adj, mp;
    logic signed [dda_pkg::MINOR_W-1:0] min_lim;
    logic                               on_screen;
    logic [dda_pkg::IDX_W-1:0]          row, col;
    logic [dda_pkg::ADDR_W-1:0]         addr;

    always_comb
    begin
        dx    = dda_pkg::DIFF_W'(in_reg.start_x) - dda_pkg::DIFF_W'(in_reg.end_x);
        dy    = dda_pkg::DIFF_W'(in_reg.start_y) - dda_pkg::DIFF_W'(in_reg.end_y);
        adx   = dx[dda_pkg::DIFF_W-1] ? -dx : dx;
        ady   = dy[dda_pkg::DIFF_W-1] ? -dy : dy;
        xmaj  = adx > ady;
        amaj  = xmaj ? in_reg.start_x : in_reg.start_y;
        amin  = xmaj ? in_reg.start_y : in_reg.start_x;
        bmaj  = xmaj ? in_reg.end_x   : in_reg.end_y;
        bmin  = xmaj ? in_reg.end_y   : in_reg.end_x;
        a_far = amaj >= bmaj;
    end

    always_comb
    begin
        dmaj_full    = dda_pkg::DIFF_W'(far_maj_reg) - dda_pkg::DIFF_W'(near_maj_reg);
        dmin_full    = dda_pkg::DIFF_W'(far_min_reg) - dda_pkg::DIFF_W'(near_min_reg);
        near_px      = near_maj_reg >>> dda_pkg::COORD_FRAC_BITS;
        far_px       = far_maj_reg >>> dda_pkg::COORD_FRAC_BITS;
        start_full   = near_maj_reg[dda_pkg::COORD_W-1] ? '0 : near_px;
        far_full     = far_px;
        maj_lim      = xmaj_reg ? dda_pkg::COORD_W'(dda_pkg::FRAME_WIDTH - 1)
                                : dda_pkg::COORD_W'(dda_pkg::FRAME_HEIGHT - 1);
        last_full    = (far_full > maj_lim) ? maj_lim : far_full;
        empty        = far_maj_reg[dda_pkg::COORD_W-1] || (start_full > last_full);
        start_scaled = (dda_pkg::OFF_W+2)'(start_full[dda_pkg::IDX_W-1:0])
                       << dda_pkg::COORD_FRAC_BITS;
        off_calc     = $signed(start_scaled) - (dda_pkg::OFF_W+2)'(far_maj_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= line_data;
        end
        if (cmd.order)
        begin
            xmaj_reg     <= xmaj;
            far_maj_reg  <= a_far ? amaj : bmaj;
            far_min_reg  <= a_far ? amin : bmin;
            near_maj_reg <= a_far ? bmaj : amaj;
            near_min_reg <= a_far ? bmin : amin;
        end
        if (cmd.prep)
        begin
            dmaj_reg     <= dmaj_full[dda_pkg::COORD_W-1:0];
            dmin_neg_reg <= dmin_full[dda_pkg::DIFF_W-1];
            dmin_abs_reg <= dmin_full[dda_pkg::DIFF_W-1] ? dda_pkg::COORD_W'(-dmin_full)
                                                         : dmin_full[dda_pkg::COORD_W-1:0];
            empty_reg    <= empty;
            m_reg        <= start_full[dda_pkg::IDX_W-1:0];
            last_reg     <= last_full[dda_pkg::IDX_W-1:0];
            off_reg      <= off_calc[dda_pkg::OFF_W-1:0];
        end
        else if (issue)
        begin
            m_reg   <= m_reg + 1'b1;
            off_reg <= off_reg + dda_pkg::OFF_STEP;
        end
        if (cmd.slope_load)
        begin
            // equal endpoints: the quotient is not used, slope is zero
            if (dmaj_reg == '0)
            begin
                slope_reg <= '0;
            end
            else
            begin
                slope_reg <= dmin_neg_reg ? -$signed({1'b0, quotient})
                                          : $signed({1'b0, quotient});
            end
        end
    end

    dda_div u_div (
        .clk          (clk),
        .start        (cmd.div_start),
        .step         (cmd.div_step),
        .dividend_abs (dmin_abs_reg),
        .divisor      (dmaj_reg),
        .quotient     (quotient)
    );

    assign advance = !out_valid_reg || pixel_ready;
    assign issue   = cmd.step_en && advance;

    // truncation toward zero: bias negative values before the arithmetic shift
    always_comb
    begin
        prod_calc  = slope_reg * off_reg;
        prod_adj   = prod_s1_reg + (prod_s1_reg[dda_pkg::PROD_W-1] ? dda_pkg::Q_ROUND
                                                                   : dda_pkg::PROD_W'(0));
        q_val      = prod_adj[dda_pkg::SLOPE_FRAC +: dda_pkg::MINOR_W];
        minor_calc = q_val + dda_pkg::MINOR_W'(far_min_reg);
        minor_adj  = minor_s2_reg + (minor_s2_reg[dda_pkg::MINOR_W-1] ? dda_pkg::PIX_ROUND
                                                                      : dda_pkg::MINOR_W'(0));
        mp         = minor_adj >>> dda_pkg::COORD_FRAC_BITS;
        min_lim    = xmaj_reg ? dda_pkg::MINOR_W'(dda_pkg::FRAME_HEIGHT)
                              : dda_pkg::MINOR_W'(dda_pkg::FRAME_WIDTH);
        on_screen  = !mp[dda_pkg::MINOR_W-1] && (mp < min_lim);
        row        = xmaj_reg ? mp[dda_pkg::IDX_W-1:0] : m_s2_reg;
        col        = xmaj_reg ? m_s2_reg : mp[dda_pkg::IDX_W-1:0];
        addr       = on_screen ? dda_pkg::ADDR_W'(dda_pkg::ADDR_W'(row)
                                  * dda_pkg::ADDR_W'(dda_pkg::FRAME_WIDTH)
                                  + dda_pkg::ADDR_W'(col))
                               : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_s1_reg  <= prod_calc;
            m_s1_reg     <= m_reg;
            last_s1_reg  <= m_reg == last_reg;
            minor_s2_reg <= minor_calc;
            m_s2_reg     <= m_s1_reg;
            last_s2_reg  <= last_s1_reg;
            out_reg.pixel_address <= addr;
            out_reg.pixel_color   <= in_reg.line_color;
            out_reg.write_enable  <= on_screen;
            out_reg.last_pixel    <= last_s2_reg;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_data  = out_reg;

    assign stat.empty_line = empty_reg;
    assign stat.issue_last = m_reg == last_reg;
    assign stat.advance    = advance;
    assign stat.pipe_idle  = !v1_reg && !v2_reg && !out_valid_reg;

endmodule

`default_nettype wire

// File: hdl/dda_ctrl.sv
// Controller: sequences setup, slope division and pixel stepping for one line.
`default_nettype none

module dda_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           line_valid,
    output logic                line_ready,
    output dda_pkg::cmd_t       cmd,
    input  wire dda_pkg::stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ORDER,
        S_PREP,
        S_CHECK,
        S_DIV,
        S_SLOPE,
        S_STEP,
        S_DRAIN
    } state_t;

    state_t                       state_reg;
    logic                         ready_reg;
    logic [dda_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:  cmd.capture    = line_valid && ready_reg;
            S_ORDER: cmd.order      = 1'b1;
            S_PREP:  cmd.prep       = 1'b1;
            S_CHECK: cmd.div_start  = !stat.empty_line;
            S_DIV:   cmd.div_step   = 1'b1;
            S_SLOPE: cmd.slope_load = 1'b1;
            S_STEP:  cmd.step_en    = 1'b1;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ready_reg   <= 1'b1;
            div_cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (line_valid && ready_reg)
                    begin
                        state_reg <= S_ORDER;
                        ready_reg <= 1'b0;
                    end
                end
                S_ORDER: state_reg <= S_PREP;
                S_PREP:  state_reg <= S_CHECK;
                S_CHECK:
                begin
                    // line misses the major range of the frame: nothing to emit
                    if (stat.empty_line)
                    begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                    else
                    begin
                        state_reg   <= S_DIV;
                        div_cnt_reg <= '0;
                    end
                end
                S_DIV:
                begin
                    if (div_cnt_reg == dda_pkg::DIV_CNT_W'(dda_pkg::DIV_STEPS - 1))
                    begin
                        state_reg <= S_SLOPE;
                    end
                    else
                    begin
                        div_cnt_reg <= div_cnt_reg + 1'b1;
                    end
                end
                S_SLOPE: state_reg <= S_STEP;
                S_STEP:
                begin
                    if (stat.advance && stat.issue_last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (stat.pipe_idle)
                    begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign line_ready = ready_reg;

endmodule

`default_nettype wire

// File: hdl/dda_line_rasterizer_top.sv
// Top level of the DDA line rasterizer: controller plus datapath.
//
// Line channel (line_valid/line_ready/line_data): one transaction is one line,
// two signed Q11.4 endpoints and a packed color. Pixel channel
// (pixel_valid/pixel_ready/pixel_data): one transaction per major-axis step,
// carrying the framebuffer address, the color, a write enable (low, with
// address 0, when the minor pixel is off screen) and a last-pixel flag.
// A line is taken only when the previous one has fully drained.
// Steps: setup (order, prep, check), the bit-serial slope divider, a
// slope load, then a 3-stage pixel pipeline (multiply, minor add, address).
// Throughput: one pixel per cycle while the receiver accepts them. A line
// that misses the frame's major range gives no pixels and frees the input
// at the check state, skipping the divider.
// When the receiver stalls, the whole pixel pipeline holds and the output
// stays stable. Reset returns the block to idle with line_ready high.
`default_nettype none

module dda_line_rasterizer_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                line_valid,
    output logic                     line_ready,
    input  wire dda_pkg::line_in_t   line_data,
    output logic                     pixel_valid,
    input  wire logic                pixel_ready,
    output dda_pkg::pixel_out_t      pixel_data
);

    dda_pkg::cmd_t  cmd;
    dda_pkg::stat_t stat;

    dda_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_valid (line_valid),
        .line_ready (line_ready),
        .cmd        (cmd),
        .stat       (stat)
    );

    dda_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .line_data   (line_data),
        .cmd         (cmd),
        .stat        (stat),
        .pixel_ready (pixel_ready),
        .pixel_valid (pixel_valid),
        .pixel_data  (pixel_data)
    );

endmodule

`default_nettype wire

// File: hdl/dda_checker.sv
// Port-level assertions for the DDA line rasterizer, bound to the top level.
`default_nettype none

module dda_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                line_valid,
    input wire logic                line_ready,
    input wire dda_pkg::line_in_t   line_data,
    input wire logic                pixel_valid,
    input wire logic                pixel_ready,
    input wire dda_pkg::pixel_out_t pixel_data
);

    // a new line is only taken once the previous one has drained
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(line_ready && pixel_valid))
        else $error("line_ready high while a pixel is pending");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (line_valid && line_ready) |=> (!line_ready && !pixel_valid))
        else $error("block not busy after a line transaction");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel_ready && pixel_data.last_pixel) |=> !pixel_valid)
        else $error("pixel after the last pixel of a line");

    a_off_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_data.write_enable) |-> (pixel_data.pixel_address == '0))
        else $error("off-screen pixel with nonzero address");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_ready) |=> (pixel_valid && $stable(pixel_data)))
        else $error("stalled pixel transaction changed");

endmodule

bind dda_line_rasterizer_top dda_checker u_dda_checker (.*);

`default_nettype wire
